/* rtl/pphr_pkg.sv */
// Shared types and constants for the pulse period heart rate block.
// Used by pphr_div and pulse_period_heart_rate_top; no dependencies.
`default_nettype none

package pphr_pkg;

    localparam int PPHR_MAX_PERIODS = 256;

    localparam int SAMPLE_W = 12;
    localparam int PPS_W    = 9;
    localparam int CNT_W    = 16;
    localparam int RATE_W   = 16;
    localparam int SUM_W    = CNT_W + 1;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd4025;
    localparam logic [PPS_W-1:0]    PPS_RST       = 9'd8;
    localparam logic [CNT_W-1:0]    GAP_RST       = 16'd0;
    localparam logic [RATE_W-1:0]   TPM_RST       = 16'd60000;
    localparam logic [RATE_W-1:0]   MIN_RATE_RST  = 16'd90;
    localparam logic [RATE_W-1:0]   MAX_RATE_RST  = 16'd160;

    localparam logic [CNT_W-1:0]    CNT_SAT       = 16'hFFFF;
    localparam logic [RATE_W-1:0]   RATE_NO_SUM   = 16'hFFFF;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_PPS       = 3'd1,
        REG_GAP       = 3'd2,
        REG_TPM       = 3'd3,
        REG_MIN_RATE  = 3'd4,
        REG_MAX_RATE  = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_CAND_W,
        S_SCAN,
        S_SCAN_W,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

/* rtl/pphr_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pphr_pkg for the word widths.
`default_nettype none

module pphr_div
    import pphr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RATE_W-1:0] i_dividend,
    input  wire logic [SUM_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [RATE_W-1:0]      o_quotient
);

    localparam int STEP_W = $clog2(RATE_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RATE_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_div;
    logic [RATE_W-1:0] r_quo;

    logic [SUM_W:0]    trial;
    logic              fits;

    assign trial = {r_rem, r_quo[RATE_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? SUM_W'(trial - {1'b0, r_div}) : trial[SUM_W-1:0];
            r_quo <= {r_quo[RATE_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* rtl/pulse_period_heart_rate_top.sv */
// Pulse period heart rate: thresholds samples, measures pulse periods and
// reports the rate from the modal high and low durations.
// Depends on pphr_pkg and pphr_div.
//
// Input channel (i_sample, i_valid, o_ready) takes one sample word per tick.
// An ordinary sample is accepted while o_ready stays high, and the next
// word may follow in the next cycle. The sample that closes the last period
// of a set starts the mode search and the division; o_ready stays low
// until the result is loaded into the output register.
// Mode search: two passes (high store, then low store) of n candidates,
// each through S_CAND, S_CAND_W, S_SCAN over the n entries and S_SCAN_W,
// set by the single read port of each store. The division (none if the
// modal sum is zero) runs one quotient bit a cycle, then the output loads.
// Output channel (o_rate, o_modal_high_ticks, o_modal_low_ticks,
// o_in_range, o_valid, i_ready) holds one result word in a register; samples
// keep flowing while it waits. If the next set completes while the receiver
// still stalls, the block holds the new result and o_ready until it drains.
// Reset (i_rst_n low, synchronous) restores the register defaults and
// clears counters, the state and o_valid; the stores need no clearing.
// Configuration goes through the APB port, register i at byte address 4*i.
`default_nettype none

module pulse_period_heart_rate_top
    import pphr_pkg::*;
#(
    parameter int MAX_PERIODS = PPHR_MAX_PERIODS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic      [APB_DW-1:0]   prdata,
    output logic                     pready,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic                i_valid,
    output logic                     o_ready,
    output logic      [RATE_W-1:0]   o_rate,
    output logic      [CNT_W-1:0]    o_modal_high_ticks,
    output logic      [CNT_W-1:0]    o_modal_low_ticks,
    output logic                     o_in_range,
    output logic                     o_valid,
    input  wire logic                i_ready
);

    localparam int AW = (MAX_PERIODS > 1) ? $clog2(MAX_PERIODS) : 1;
    localparam int NW = $clog2(MAX_PERIODS + 1);
    localparam int CW = (NW > PPS_W) ? NW : PPS_W;

    // configuration
    logic [SAMPLE_W-1:0] r_thr;
    logic [PPS_W-1:0]    r_pps;
    logic [CNT_W-1:0]    r_gap_ticks;
    logic [RATE_W-1:0]   r_tpm;
    logic [RATE_W-1:0]   r_min_rate;
    logic [RATE_W-1:0]   r_max_rate;

    // period measurement
    logic [CNT_W-1:0]    r_high_cnt;
    logic [CNT_W-1:0]    r_low_cnt;
    logic                r_seen_low;
    logic [NW-1:0]       r_pidx;
    logic [CNT_W-1:0]    r_gap_left;

    // stores
    logic [CNT_W-1:0]    r_high_mem [MAX_PERIODS];
    logic [CNT_W-1:0]    r_low_mem  [MAX_PERIODS];
    logic [CNT_W-1:0]    r_hrd;
    logic [CNT_W-1:0]    r_lrd;

    // sequencer and mode search
    t_state              r_state;
    t_state              n_state;
    logic [NW-1:0]       r_n;
    logic [AW-1:0]       r_i;
    logic [AW-1:0]       r_j;
    logic                r_pass;
    logic [CNT_W-1:0]    r_cand;
    logic [NW-1:0]       r_hits;
    logic [CNT_W-1:0]    r_best;
    logic [NW-1:0]       r_best_hits;
    logic [CNT_W-1:0]    r_mh;
    logic [CNT_W-1:0]    r_ml;
    logic [RATE_W-1:0]   r_rate;

    // output register
    logic                r_out_valid;
    logic [RATE_W-1:0]   r_out_rate;
    logic [CNT_W-1:0]    r_out_mh;
    logic [CNT_W-1:0]    r_out_ml;
    logic                r_out_in_range;

    logic                cfg_wr;
    logic                in_acc;
    logic                is_high;
    logic                period_end;
    logic                set_done;
    logic [CW-1:0]       pps_c;
    logic [NW-1:0]       set_n;
    logic [NW:0]         pidx_inc;
    logic [AW-1:0]       rd_addr;
    logic [CNT_W-1:0]    rdata;
    logic                match;
    logic [NW-1:0]       hits_fin;
    logic [NW-1:0]       n_m1;
    logic                i_last;
    logic                j_last;
    logic [SUM_W-1:0]    mode_sum;
    logic                sum_zero;
    logic                div_start;
    logic                div_done;
    logic [RATE_W-1:0]   div_quo;
    logic                out_free;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_THRESHOLD: prdata = APB_DW'(r_thr);
            REG_PPS:       prdata = APB_DW'(r_pps);
            REG_GAP:       prdata = APB_DW'(r_gap_ticks);
            REG_TPM:       prdata = APB_DW'(r_tpm);
            REG_MIN_RATE:  prdata = APB_DW'(r_min_rate);
            REG_MAX_RATE:  prdata = APB_DW'(r_max_rate);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THRESHOLD_RST;
            r_pps       <= PPS_RST;
            r_gap_ticks <= GAP_RST;
            r_tpm       <= TPM_RST;
            r_min_rate  <= MIN_RATE_RST;
            r_max_rate  <= MAX_RATE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_THRESHOLD: r_thr       <= pwdata[SAMPLE_W-1:0];
                REG_PPS:       r_pps       <= pwdata[PPS_W-1:0];
                REG_GAP:       r_gap_ticks <= pwdata[CNT_W-1:0];
                REG_TPM:       r_tpm       <= pwdata[RATE_W-1:0];
                REG_MIN_RATE:  r_min_rate  <= pwdata[RATE_W-1:0];
                REG_MAX_RATE:  r_max_rate  <= pwdata[RATE_W-1:0];
                default:       ;
            endcase
        end
    end

    // sample intake
    assign o_ready    = (r_state == S_IDLE);
    assign in_acc     = i_valid && o_ready;
    assign is_high    = i_sample >= r_thr;
    assign period_end = in_acc && (r_gap_left == '0) && is_high && r_seen_low;

    assign pps_c = CW'(r_pps);
    always_comb begin
        priority if (pps_c == '0) begin
            set_n = NW'(1);
        end else if (pps_c > CW'(MAX_PERIODS)) begin
            set_n = NW'(MAX_PERIODS);
        end else begin
            set_n = NW'(pps_c);
        end
    end

    assign pidx_inc = {1'b0, r_pidx} + 1'b1;
    assign set_done = period_end && (pidx_inc >= {1'b0, set_n});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_cnt <= '0;
            r_low_cnt  <= '0;
            r_seen_low <= 1'b0;
            r_pidx     <= '0;
            r_gap_left <= '0;
        end else if (in_acc) begin
            if (r_gap_left != '0) begin
                r_gap_left <= r_gap_left - 1'b1;
            end else if (period_end) begin
                r_high_cnt <= '0;
                r_low_cnt  <= '0;
                r_seen_low <= 1'b0;
                r_gap_left <= r_gap_ticks;
                r_pidx     <= set_done ? '0 : pidx_inc[NW-1:0];
            end else if (is_high) begin
                if (r_high_cnt != CNT_SAT) r_high_cnt <= r_high_cnt + 1'b1;
            end else begin
                r_seen_low <= 1'b1;
                if (r_low_cnt != CNT_SAT) r_low_cnt <= r_low_cnt + 1'b1;
            end
        end
    end

    always_comb begin
        unique case (r_state)
            S_SCAN:  rd_addr = r_j;
            default: rd_addr = r_i;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (period_end && (r_pidx < NW'(MAX_PERIODS))) begin
            r_high_mem[r_pidx[AW-1:0]] <= r_high_cnt;
            r_low_mem[r_pidx[AW-1:0]]  <= r_low_cnt;
        end
        r_hrd <= r_high_mem[rd_addr];
        r_lrd <= r_low_mem[rd_addr];
    end

    // mode search and division
    assign rdata    = r_pass ? r_lrd : r_hrd;
    assign match    = (rdata == r_cand);
    assign hits_fin = r_hits + NW'(match);
    assign n_m1     = r_n - 1'b1;
    assign i_last   = (NW'(r_i) == n_m1);
    assign j_last   = (NW'(r_j) == n_m1);
    assign mode_sum = {1'b0, r_mh} + {1'b0, r_ml};
    assign sum_zero = (mode_sum == '0);
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE:     if (set_done) n_state = S_CAND;
            S_CAND:     n_state = S_CAND_W;
            S_CAND_W:   n_state = S_SCAN;
            S_SCAN:     if (j_last) n_state = S_SCAN_W;
            S_SCAN_W: begin
                if (i_last && r_pass) n_state = S_DIV_GO;
                else                  n_state = S_CAND;
            end
            S_DIV_GO: begin
                div_start = !sum_zero;
                n_state   = sum_zero ? S_OUT : S_DIV_WAIT;
            end
            S_DIV_WAIT: if (div_done) n_state = S_OUT;
            S_OUT:      if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_n         <= set_n;
                r_i         <= '0;
                r_pass      <= 1'b0;
                r_best_hits <= '0;
            end
            S_CAND_W: begin
                r_cand <= rdata;
                r_hits <= '0;
                r_j    <= '0;
            end
            S_SCAN: begin
                r_j <= r_j + 1'b1;
                if (r_j != '0) r_hits <= hits_fin;
            end
            S_SCAN_W: begin
                if (i_last) begin
                    r_i         <= '0;
                    r_pass      <= 1'b1;
                    r_best_hits <= '0;
                    if (r_pass) begin
                        r_ml <= (hits_fin > r_best_hits) ? r_cand : r_best;
                    end else begin
                        r_mh <= (hits_fin > r_best_hits) ? r_cand : r_best;
                    end
                end else begin
                    r_i <= r_i + 1'b1;
                    if (hits_fin > r_best_hits) begin
                        r_best      <= r_cand;
                        r_best_hits <= hits_fin;
                    end
                end
            end
            S_DIV_GO:   if (sum_zero) r_rate <= RATE_NO_SUM;
            S_DIV_WAIT: if (div_done) r_rate <= div_quo;
            default:    ;
        endcase
    end

    pphr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_tpm),
        .i_divisor  (mode_sum),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_rate     <= r_rate;
            r_out_mh       <= r_mh;
            r_out_ml       <= r_ml;
            r_out_in_range <= (r_rate >= r_min_rate) && (r_rate <= r_max_rate);
        end
    end

    assign o_valid            = r_out_valid;
    assign o_rate             = r_out_rate;
    assign o_modal_high_ticks = r_out_mh;
    assign o_modal_low_ticks  = r_out_ml;
    assign o_in_range         = r_out_in_range;

    a_div_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_pidx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_pidx < NW'(MAX_PERIODS)))
        else $error("period index beyond store depth");

    a_hits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_W) |-> (hits_fin <= r_n) && (hits_fin != '0))
        else $error("hit count outside the set size");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> o_valid && (r_state == S_IDLE))
        else $error("result not presented after the set completed");

endmodule

`default_nettype wire
